### rtl/rate_limited_event_scheduler_macros.svh
// Assertion macros for the rate-limited event scheduler.
// Each macro expects i_clk and i_rst_n to exist in the module that uses it.
`ifndef RATE_LIMITED_EVENT_SCHEDULER_MACROS_SVH
`define RATE_LIMITED_EVENT_SCHEDULER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define RLES_ASSERT_IMP(lbl, cond, conc, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (conc)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define RLES_ASSERT_NXT(lbl, cond, conc, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (conc)) \
        else $error(msg);

`endif

### rtl/rles_pkg.sv
// Shared types and constants of the rate-limited event scheduler.
// No dependencies; used by the front end, the engine and the top level.
`timescale 1ns / 1ps
package rles_pkg;

    localparam int IDX_W     = 5;
    localparam int ELAPSED_W = 16;
    localparam int CNT_W     = 24;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [1:0] {
        REQ_TICK    = 2'd0,
        REQ_REQUEST = 2'd1,
        REQ_SET     = 2'd2,
        REQ_SERVICE = 2'd3
    } t_req_kind;

    // Decoded item handed from the front to the back end.
    typedef struct packed {
        t_req_kind              kind;
        logic                   in_range;
        logic [ELAPSED_W-1:0]   elapsed;
        logic [IDX_W-1:0]       idx;
        logic [CNT_W-1:0]       auto_period;
        logic [CNT_W-1:0]       limit_period;
    } t_cmd;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] served_index;
    } t_result;

endpackage

### rtl/rles_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module rles_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/rles_front.sv
// Front end: accepts stream items, decodes them and queues them (two deep).
// Depends on rles_pkg.
`timescale 1ns / 1ps
module rles_front
    import rles_pkg::*;
#(
    parameter int NUM_ENTRIES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,
    output logic        o_cmd_valid,
    output t_cmd        o_cmd,
    input  logic        i_cmd_pop
);

    localparam logic [8:0] NUM_E9 = 9'(NUM_ENTRIES);

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    t_cmd       dec;
    logic       push;

    always_comb begin
        dec.kind         = t_req_kind'(s_axis_tuser);
        dec.elapsed      = s_axis_tdata[15:0];
        dec.idx          = s_axis_tdata[20:16];
        dec.auto_period  = s_axis_tdata[44:21];
        dec.limit_period = s_axis_tdata[68:45];
        dec.in_range     = ({4'b0, s_axis_tdata[20:16]} < NUM_E9);
    end

    assign s_axis_tready = (r_cnt != 2'd2);
    assign push          = s_axis_tvalid && s_axis_tready;
    assign o_cmd_valid   = (r_cnt != 2'd0);
    assign o_cmd         = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (push && !i_cmd_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!push && i_cmd_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_cmd_pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= dec;
        end
    end

endmodule

### rtl/rles_engine.sv
// Back end: executes queued items (tick sweep, request, set, service scan).
// Depends on rles_pkg, rles_ram and the assertion macro header.
`timescale 1ns / 1ps
`include "rate_limited_event_scheduler_macros.svh"
module rles_engine
    import rles_pkg::*;
#(
    parameter int NUM_ENTRIES = 32
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cmd_valid,
    input  t_cmd    i_cmd,
    output logic    o_cmd_pop,
    output logic    o_res_valid,
    output t_result o_res,
    input  logic    i_res_ready
);

    localparam int IW = $clog2(NUM_ENTRIES);
    localparam int CW = IW + 1;
    localparam logic [CW-1:0] N_CW = CW'(NUM_ENTRIES);
    localparam logic [CW-1:0] LAST = CW'(NUM_ENTRIES - 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SWEEP = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_RESP  = 4'b1000
    } t_eng_state;

    t_eng_state       r_state;
    t_cmd             r_cmd;
    logic [CW-1:0]    r_issue;
    logic             r_s1_v;
    logic [IW-1:0]    r_s1_idx;
    logic             r_s1_cv;
    logic             r_s1_pv;
    logic             r_s2_v;
    logic [IW-1:0]    r_s2_idx;
    logic [CNT_W-1:0] r_s2_sum;
    logic [CNT_W-1:0] r_s2_ap;
    logic [CNT_W-1:0] r_s2_lp;
    logic [NUM_ENTRIES-1:0] r_pend;
    logic [NUM_ENTRIES-1:0] r_req;
    logic             r_cnt_init;
    logic [NUM_ENTRIES-1:0] r_pvld;
    logic [IW-1:0]    r_ptr;
    logic [IW-1:0]    r_scan_ptr;
    logic [CW-1:0]    r_scan_cnt;
    logic             r_found;
    logic [IW-1:0]    r_served;

    logic               issuing;
    logic [IW-1:0]      rd_addr;
    logic [CNT_W-1:0]   cnt_rdata;
    logic [2*CNT_W-1:0] per_rdata;
    logic [CNT_W-1:0]   cnt_eff;
    logic [CNT_W:0]     sum_ext;
    logic [CNT_W-1:0]   n_sum;
    logic               lim_ok;
    logic               auto_hit;
    logic               fire_auto;
    logic               fire_req;
    logic [CNT_W-1:0]   cnt_wdata;
    logic               per_we;
    logic [IW-1:0]      cmd_idx;
    logic               scan_hit;
    logic [IW-1:0]      scan_next;

    assign cmd_idx   = IW'(i_cmd.idx);
    assign o_cmd_pop = (r_state == ST_IDLE) && i_cmd_valid;
    assign per_we    = o_cmd_pop && (i_cmd.kind == REQ_SET) && i_cmd.in_range;
    assign issuing   = (r_state == ST_SWEEP) && (r_issue != N_CW);
    assign rd_addr   = r_issue[IW-1:0];

    // Counter and period storage; counters read as zero until the first sweep
    // has written every entry, periods never written read as zero via valid bits
    rles_ram #(.WIDTH(CNT_W), .DEPTH(NUM_ENTRIES)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (r_s2_v),
        .i_waddr (r_s2_idx),
        .i_wdata (cnt_wdata),
        .i_raddr (rd_addr),
        .o_rdata (cnt_rdata)
    );

    rles_ram #(.WIDTH(2*CNT_W), .DEPTH(NUM_ENTRIES)) u_per_ram (
        .i_clk   (i_clk),
        .i_we    (per_we),
        .i_waddr (cmd_idx),
        .i_wdata ({i_cmd.limit_period, i_cmd.auto_period}),
        .i_raddr (rd_addr),
        .o_rdata (per_rdata)
    );

    // Stage 1: saturating add of the elapsed time
    always_comb begin
        cnt_eff = r_s1_cv ? cnt_rdata : '0;
        sum_ext = {1'b0, cnt_eff} + (CNT_W+1)'(r_cmd.elapsed);
        n_sum   = sum_ext[CNT_W] ? CNT_MAX : sum_ext[CNT_W-1:0];
    end

    // Stage 2: rule check and write back
    always_comb begin
        lim_ok    = (r_s2_lp == '0) || (r_s2_sum >= r_s2_lp);
        auto_hit  = (r_s2_ap != '0) && (r_s2_sum >= r_s2_ap);
        fire_auto = r_s2_v && !r_pend[r_s2_idx] && lim_ok && auto_hit;
        fire_req  = r_s2_v && !r_pend[r_s2_idx] && lim_ok && !auto_hit && r_req[r_s2_idx];
        cnt_wdata = (fire_auto || fire_req) ? '0 : r_s2_sum;
    end

    assign scan_hit  = r_pend[r_scan_ptr];
    assign scan_next = ({1'b0, r_scan_ptr} == LAST) ? '0 : r_scan_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_issue    <= '0;
            r_s1_v     <= 1'b0;
            r_s2_v     <= 1'b0;
            r_pend     <= '0;
            r_req      <= '0;
            r_cnt_init <= 1'b0;
            r_pvld     <= '0;
            r_ptr      <= '0;
            r_scan_ptr <= '0;
            r_scan_cnt <= '0;
            r_found    <= 1'b0;
        end else begin
            r_s1_v <= issuing;
            r_s2_v <= r_s1_v;
            if (fire_auto || fire_req) begin
                r_pend[r_s2_idx] <= 1'b1;
            end
            if (fire_req) begin
                r_req[r_s2_idx] <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_cmd_valid) begin
                        r_found <= 1'b0;
                        unique case (i_cmd.kind)
                            REQ_TICK: begin
                                r_issue <= '0;
                                r_state <= ST_SWEEP;
                            end
                            REQ_REQUEST: begin
                                if (i_cmd.in_range) begin
                                    r_req[cmd_idx] <= 1'b1;
                                end
                                r_state <= ST_RESP;
                            end
                            REQ_SET: begin
                                if (i_cmd.in_range) begin
                                    r_pvld[cmd_idx] <= 1'b1;
                                end
                                r_state <= ST_RESP;
                            end
                            REQ_SERVICE: begin
                                r_scan_ptr <= r_ptr;
                                r_scan_cnt <= '0;
                                r_state    <= ST_SCAN;
                            end
                            default: r_state <= ST_RESP;
                        endcase
                    end
                end
                ST_SWEEP: begin
                    if (issuing) begin
                        r_issue <= r_issue + 1'b1;
                    end else if (!r_s1_v && !r_s2_v) begin
                        // every counter entry has now been written back
                        r_cnt_init <= 1'b1;
                        r_state    <= ST_RESP;
                    end
                end
                ST_SCAN: begin
                    if (scan_hit) begin
                        r_pend[r_scan_ptr] <= 1'b0;
                        r_found            <= 1'b1;
                        r_ptr              <= scan_next;
                        r_state            <= ST_RESP;
                    end else if (r_scan_cnt == LAST) begin
                        r_state <= ST_RESP;
                    end else begin
                        r_scan_ptr <= scan_next;
                        r_scan_cnt <= r_scan_cnt + 1'b1;
                    end
                end
                ST_RESP: begin
                    if (i_res_ready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
        if (r_state == ST_SCAN && scan_hit) begin
            r_served <= r_scan_ptr;
        end
        r_s1_idx <= rd_addr;
        r_s1_cv  <= r_cnt_init;
        r_s1_pv  <= r_pvld[rd_addr];
        r_s2_idx <= r_s1_idx;
        r_s2_sum <= n_sum;
        r_s2_ap  <= r_s1_pv ? per_rdata[CNT_W-1:0] : '0;
        r_s2_lp  <= r_s1_pv ? per_rdata[2*CNT_W-1:CNT_W] : '0;
    end

    assign o_res_valid        = (r_state == ST_RESP);
    assign o_res.found        = r_found;
    assign o_res.served_index = r_found ? IDX_W'(r_served) : '0;

    `RLES_ASSERT_IMP(a_s2_in_sweep, r_s2_v, r_state == ST_SWEEP, "write-back outside sweep")
    `RLES_ASSERT_IMP(a_pop_idle, o_cmd_pop, r_state == ST_IDLE, "queue popped while busy")
    `RLES_ASSERT_NXT(a_serve_clears, r_state == ST_SCAN && scan_hit, !r_pend[r_served], "served entry still pending")
    `RLES_ASSERT_IMP(a_found_srv, o_res_valid && r_found, r_cmd.kind == REQ_SERVICE, "found on non-service item")

endmodule

### rtl/rate_limited_event_scheduler.sv
// Rate-limited event scheduler, top level: front queue, engine, output register.
// Request and set go straight to the response state; service scans one entry per cycle
// from the round-robin pointer; tick sweeps the counter RAM, one entry per cycle
// through a three-stage read/add/check pipeline.
// Throughput: one item at a time in the engine; the two-deep input queue keeps taking
// transfers while it has room. Synchronous active-low reset clears control, flags and valid bits.
`timescale 1ns / 1ps
module rate_limited_event_scheduler
    import rles_pkg::*;
#(
    parameter int NUM_ENTRIES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [15:0] elapsed, [20:16] entry_index, [44:21] auto_period,
    // [68:45] limit_period, [71:69] zero
    input  logic [71:0] s_axis_tdata,
    // [1:0] req_type
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [4:0] served_index, [7:5] zero
    output logic [7:0]  m_axis_tdata,
    // [0] found
    output logic        m_axis_tuser
);

    logic    cmd_valid;
    t_cmd    cmd;
    logic    cmd_pop;
    logic    res_valid;
    t_result res;
    logic    res_ready;

    // Output register: holds one result so the engine can move on
    logic    r_out_valid;
    t_result r_out;

    rles_front #(.NUM_ENTRIES(NUM_ENTRIES)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_cmd_valid   (cmd_valid),
        .o_cmd         (cmd),
        .i_cmd_pop     (cmd_pop)
    );

    rles_engine #(.NUM_ENTRIES(NUM_ENTRIES)) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    // Engine may hand over a result when the slot is empty or being drained
    assign res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out.served_index};
    assign m_axis_tuser  = r_out.found;

endmodule
